### hw/rtl/lcdb_pkg.sv
// Shared types, widths and reset constants for the LED chaser with debounced buttons.
package lcdb_pkg;

    // Number of LEDs driven by the chaser.
    localparam int LED_COUNT = 10;

    localparam int COUNT_W  = 8;
    localparam int PERIOD_W = 12;
    localparam int CFG_W    = 12;
    localparam int CFG_IDX_W = 2;

    // Reset values of the configuration and state.
    localparam logic [COUNT_W-1:0]  DEBOUNCE_RESET   = 8'd50;
    localparam logic [COUNT_W-1:0]  STEP_RESET       = 8'd50;
    localparam logic [PERIOD_W-1:0] PERIOD_MIN_RESET = 12'd50;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX_RESET = 12'd3000;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET     = 12'd500;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_STEP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_MIN     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_MAX     = 2'd3;

    typedef struct packed {
        logic btn_dir_n;
        logic btn_slower_n;
        logic btn_faster_n;
    } in_t;

    typedef struct packed {
        logic [LED_COUNT-1:0] led_pattern;
        logic                 direction;
        logic [PERIOD_W-1:0]  period;
    } out_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  debounce_ticks;
        logic [COUNT_W-1:0]  period_step;
        logic [PERIOD_W-1:0] period_min;
        logic [PERIOD_W-1:0] period_max;
    } cfg_t;

    // Debounced button events for one tick.
    typedef struct packed {
        logic dir;
        logic slower;
        logic faster;
    } fire_t;

endpackage

### hw/rtl/led_chaser_debounced_buttons.sv
// Top level of the LED chaser with three debounced buttons.
//
// Each request on the s_ channel is one timer tick carrying the three
// active-low button levels. Every accepted tick produces exactly one
// result on the m_ channel: the LED pattern, direction and period after
// that tick's updates.
// A tick's result is registered at the clock edge that accepts the
// tick. Throughput is one tick per cycle; the limit is the single
// result register, which is refilled in the same cycle it is
// emptied. When the receiver stalls, the result register holds its
// value and s_ready drops, so no further tick is taken until the
// result leaves. The user must write configuration through cfg_we,
// cfg_index and cfg_data only while no tick is in flight; the block
// does not enforce this. Writes take effect at the next tick. A
// synchronous active-low reset restores the default configuration,
// lights the lowest LED, sets the forward direction and a period of
// 500, arms all buttons and empties the result register.
module led_chaser_debounced_buttons (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  lcdb_pkg::in_t                  s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output lcdb_pkg::out_t                 m_data,
    input  logic                           cfg_we,
    input  logic [lcdb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lcdb_pkg::CFG_W-1:0]     cfg_data
);
    import lcdb_pkg::*;

    cfg_t                 cfg_reg;
    fire_t                fire;
    logic                 tick;
    logic [PERIOD_W-1:0]  period;
    logic [PERIOD_W-1:0]  period_next;
    logic [LED_COUNT-1:0] ring_next;
    logic                 dir_next;
    logic                 m_valid_reg;
    out_t                 m_data_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign tick    = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Configuration register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks <= DEBOUNCE_RESET;
            cfg_reg.period_step    <= STEP_RESET;
            cfg_reg.period_min     <= PERIOD_MIN_RESET;
            cfg_reg.period_max     <= PERIOD_MAX_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_DEBOUNCE_TICKS: cfg_reg.debounce_ticks <= cfg_data[COUNT_W-1:0];
                CFG_PERIOD_STEP:    cfg_reg.period_step    <= cfg_data[COUNT_W-1:0];
                CFG_PERIOD_MIN:     cfg_reg.period_min     <= cfg_data[PERIOD_W-1:0];
                CFG_PERIOD_MAX:     cfg_reg.period_max     <= cfg_data[PERIOD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // One debouncer per button.
    lcdb_debounce u_deb_dir (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tick      (tick),
        .level_n   (s_data.btn_dir_n),
        .threshold (cfg_reg.debounce_ticks),
        .fire      (fire.dir)
    );

    lcdb_debounce u_deb_slower (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tick      (tick),
        .level_n   (s_data.btn_slower_n),
        .threshold (cfg_reg.debounce_ticks),
        .fire      (fire.slower)
    );

    lcdb_debounce u_deb_faster (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tick      (tick),
        .level_n   (s_data.btn_faster_n),
        .threshold (cfg_reg.debounce_ticks),
        .fire      (fire.faster)
    );

    lcdb_period u_period (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .tick        (tick),
        .fire        (fire),
        .cfg         (cfg_reg),
        .period      (period),
        .period_next (period_next)
    );

    lcdb_chaser u_chaser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tick       (tick),
        .dir_toggle (fire.dir),
        .period     (period),
        .ring_next  (ring_next),
        .dir_next   (dir_next)
    );

    // Result register: loaded with the post-tick state on every accepted tick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (tick) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (tick) begin
            m_data_reg.led_pattern <= ring_next;
            m_data_reg.direction   <= dir_next;
            m_data_reg.period      <= period_next;
        end
    end

endmodule

### hw/rtl/lcdb_debounce.sv
// Debouncer for one active-low button: fires once per hold, re-arms on release.
module lcdb_debounce (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        tick,
    input  logic                        level_n,
    input  logic [lcdb_pkg::COUNT_W-1:0] threshold,
    output logic                        fire
);
    import lcdb_pkg::*;

    logic               armed_reg, armed_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               pressed;

    assign pressed = ~level_n;
    assign fire    = armed_reg && pressed && (count_reg >= threshold);

    // Held long enough fires and disarms; a release re-arms and clears the count.
    always_comb begin
        armed_next = armed_reg;
        count_next = '0;
        if (armed_reg && pressed) begin
            if (fire) begin
                armed_next = 1'b0;
            end else begin
                count_next = count_reg + 1'b1;
            end
        end else if (!pressed) begin
            armed_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg <= 1'b1;
            count_reg <= '0;
        end else if (tick) begin
            armed_reg <= armed_next;
            count_reg <= count_next;
        end
    end

endmodule

### hw/rtl/lcdb_period.sv
// Chaser period register with saturating slower and faster adjustments.
module lcdb_period (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         tick,
    input  lcdb_pkg::fire_t              fire,
    input  lcdb_pkg::cfg_t               cfg,
    output logic [lcdb_pkg::PERIOD_W-1:0] period,
    output logic [lcdb_pkg::PERIOD_W-1:0] period_next
);
    import lcdb_pkg::*;

    logic [PERIOD_W-1:0] period_reg;
    logic [PERIOD_W:0]   sum;
    logic [PERIOD_W-1:0] after_slower;
    logic [PERIOD_W:0]   diff;

    assign period = period_reg;

    // Slower is applied first, then faster on its result.
    always_comb begin
        sum = {1'b0, period_reg} + {{(PERIOD_W + 1 - COUNT_W){1'b0}}, cfg.period_step};
        after_slower = period_reg;
        if (fire.slower) begin
            if (sum > {1'b0, cfg.period_max}) begin
                after_slower = cfg.period_max;
            end else begin
                after_slower = sum[PERIOD_W-1:0];
            end
        end

        // The top bit of the difference is the borrow, meaning a negative result.
        diff = {1'b0, after_slower} - {{(PERIOD_W + 1 - COUNT_W){1'b0}}, cfg.period_step};
        period_next = after_slower;
        if (fire.faster) begin
            if (diff[PERIOD_W] || (diff[PERIOD_W-1:0] < cfg.period_min)) begin
                period_next = cfg.period_min;
            end else begin
                period_next = diff[PERIOD_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= PERIOD_RESET;
        end else if (tick) begin
            period_reg <= period_next;
        end
    end

endmodule

### hw/rtl/lcdb_chaser.sv
// One-hot LED ring, its step timer and the chase direction.
module lcdb_chaser (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          tick,
    input  logic                          dir_toggle,
    input  logic [lcdb_pkg::PERIOD_W-1:0] period,
    output logic [lcdb_pkg::LED_COUNT-1:0] ring_next,
    output logic                          dir_next
);
    import lcdb_pkg::*;

    logic [LED_COUNT-1:0] ring_reg;
    logic                 dir_reg;
    logic [PERIOD_W-1:0]  timer_reg, timer_next;
    logic [LED_COUNT-1:0] shifted;

    // The ring steps with the direction held before this tick's button action.
    always_comb begin
        ring_next  = ring_reg;
        timer_next = timer_reg + 1'b1;
        shifted    = '0;
        if (timer_reg >= period) begin
            timer_next = '0;
            if (dir_reg) begin
                if (ring_reg[LED_COUNT-1]) begin
                    ring_next = {{(LED_COUNT-1){1'b0}}, 1'b1};
                end else begin
                    ring_next = ring_reg << 1;
                end
            end else begin
                shifted = ring_reg >> 1;
                if (shifted == '0) begin
                    ring_next = {1'b1, {(LED_COUNT-1){1'b0}}};
                end else begin
                    ring_next = shifted;
                end
            end
        end
        dir_next = dir_reg ^ dir_toggle;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_reg  <= {{(LED_COUNT-1){1'b0}}, 1'b1};
            dir_reg   <= 1'b1;
            timer_reg <= '0;
        end else if (tick) begin
            ring_reg  <= ring_next;
            dir_reg   <= dir_next;
            timer_reg <= timer_next;
        end
    end

endmodule

### hw/rtl/lcdb_checker.sv
// Port-level checks for the LED chaser top level, bound to every instance.
module lcdb_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input lcdb_pkg::out_t                 m_data,
    input logic                           m_valid,
    input logic                           m_ready
);
    import lcdb_pkg::*;

    // A stalled result keeps its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // A pending, stalled result blocks new ticks.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("tick accepted while result stalled");

    // A taken result with no new tick leaves the output empty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !s_valid |=> !m_valid)
        else $error("result repeated without a tick");

    // Every valid result lights exactly one LED.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot(m_data.led_pattern))
        else $error("LED pattern not one-hot");

endmodule

bind led_chaser_debounced_buttons lcdb_checker u_lcdb_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_data  (m_data),
    .m_valid (m_valid),
    .m_ready (m_ready)
);

### bench/led_chaser_debounced_buttons_tb.sv
// Self-checking testbench for the LED chaser with debounced buttons.
module led_chaser_debounced_buttons_tb;
    import lcdb_pkg::*;

    localparam int CYCLE_LIMIT = 100000;
    localparam int IDLE_PCT    = 21;
    localparam int PHASE_TICKS = 300;
    localparam int PHASES      = 6;

    // Button positions in the debouncer arrays.
    localparam int BTN_DIR    = 0;
    localparam int BTN_SLOWER = 1;
    localparam int BTN_FASTER = 2;

    localparam logic [LED_COUNT-1:0] LED_TOP = {1'b1, {(LED_COUNT-1){1'b0}}};

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_t                  s_data    = '1;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_t                 m_data;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    // Predicted chaser state and its copy of the registers.
    cfg_t                 cfg_q;
    logic [LED_COUNT-1:0] ring_q;
    logic                 fwd_q;
    logic [PERIOD_W-1:0]  period_q;
    logic [PERIOD_W-1:0]  timer_q;
    logic                 armed_q [3];
    logic [COUNT_W-1:0]   hold_q  [3];

    out_t expected_leds_q [$];
    out_t want_out;
    bit   steady = 1'b0;
    int   failures = 0;
    int   ticks_sent = 0;
    int   results_checked = 0;
    int   settings_written = 0;
    int   cycle_count = 0;

    led_chaser_debounced_buttons dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Restore the predicted state to its reset values.
    function automatic void reset_chaser_model();
        cfg_q.debounce_ticks = DEBOUNCE_RESET;
        cfg_q.period_step    = STEP_RESET;
        cfg_q.period_min     = PERIOD_MIN_RESET;
        cfg_q.period_max     = PERIOD_MAX_RESET;
        ring_q   = LED_COUNT'(1);
        fwd_q    = 1'b1;
        period_q = PERIOD_RESET;
        timer_q  = '0;
        for (int b = 0; b < 3; b++) begin
            armed_q[b] = 1'b1;
            hold_q[b]  = '0;
        end
    endfunction

    // One debouncer step; returns 1 on the tick the button action fires.
    function automatic bit button_fires(input int b, input bit pressed);
        if (armed_q[b] && pressed) begin
            if (hold_q[b] >= cfg_q.debounce_ticks) begin
                hold_q[b]  = '0;
                armed_q[b] = 1'b0;
                return 1'b1;
            end
            hold_q[b] = hold_q[b] + 1'b1;
            return 1'b0;
        end
        if (!pressed)
            armed_q[b] = 1'b1;
        hold_q[b] = '0;
        return 1'b0;
    endfunction

    // Advance the predicted chaser by one tick and return its outputs.
    function automatic out_t chase_tick(input in_t btn);
        out_t              r;
        logic [PERIOD_W:0] up;
        int                down;
        if (timer_q >= period_q) begin
            if (fwd_q) begin
                ring_q = ring_q[LED_COUNT-1] ? LED_COUNT'(1) : ring_q << 1;
            end else begin
                ring_q = ring_q >> 1;
                if (ring_q == '0)
                    ring_q = LED_TOP;
            end
            timer_q = '0;
        end else begin
            timer_q = timer_q + 1'b1;
        end
        if (button_fires(BTN_DIR, !btn.btn_dir_n))
            fwd_q = ~fwd_q;
        // Slower is applied before faster when both fire on one tick.
        if (button_fires(BTN_SLOWER, !btn.btn_slower_n)) begin
            up = {1'b0, period_q} + (PERIOD_W + 1)'(cfg_q.period_step);
            period_q = (up > {1'b0, cfg_q.period_max}) ? cfg_q.period_max
                                                       : up[PERIOD_W-1:0];
        end
        if (button_fires(BTN_FASTER, !btn.btn_faster_n)) begin
            down = int'(period_q) - int'(cfg_q.period_step);
            period_q = (down < int'(cfg_q.period_min)) ? cfg_q.period_min
                                                       : down[PERIOD_W-1:0];
        end
        r.led_pattern = ring_q;
        r.direction   = fwd_q;
        r.period      = period_q;
        return r;
    endfunction

    // Button levels from pressed flags.
    function automatic in_t press(input bit dir, input bit slower, input bit faster);
        in_t r;
        r.btn_dir_n    = !dir;
        r.btn_slower_n = !slower;
        r.btn_faster_n = !faster;
        return r;
    endfunction

    // Send one tick request, idling first at random, and record its prediction.
    task automatic send_tick(input in_t btn);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= btn;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        expected_leds_q.push_back(chase_tick(btn));
        ticks_sent++;
    endtask

    // Stop sending and wait until every predicted result has come back.
    task automatic wait_results_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_leds_q.size() != 0)
            @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_DEBOUNCE_TICKS: cfg_q.debounce_ticks = value[COUNT_W-1:0];
            CFG_PERIOD_STEP:    cfg_q.period_step    = value[COUNT_W-1:0];
            CFG_PERIOD_MIN:     cfg_q.period_min     = value[PERIOD_W-1:0];
            CFG_PERIOD_MAX:     cfg_q.period_max     = value[PERIOD_W-1:0];
            default: ;
        endcase
    endtask

    // Write all four registers; the unused upper bits of the 8-bit ones get noise.
    task automatic set_chaser_regs(input int deb, input int step, input int pmin, input int pmax);
        wait_results_drained();
        write_reg(CFG_DEBOUNCE_TICKS, {4'($urandom_range(0, 15)), 8'(deb)});
        write_reg(CFG_PERIOD_STEP, {4'($urandom_range(0, 15)), 8'(step)});
        write_reg(CFG_PERIOD_MIN, 12'(pmin));
        write_reg(CFG_PERIOD_MAX, 12'(pmax));
        settings_written++;
    endtask

    // Ticks with no button pressed show the reset pattern, direction and period.
    task automatic test_after_reset();
        repeat (3) send_tick(press(0, 0, 0));
    endtask

    // Zero debounce, clamping at the top, both speed buttons at once, period zero.
    task automatic test_fast_presses();
        set_chaser_regs(0, 255, 0, 600);
        send_tick(press(1, 0, 0));
        send_tick(press(0, 0, 0));
        send_tick(press(0, 1, 1));
        send_tick(press(0, 0, 0));
        send_tick(press(0, 0, 1));
        send_tick(press(0, 0, 0));
        send_tick(press(0, 0, 1));
        // Period is now zero: the chaser moves backward every tick and wraps from the lowest LED to the top.
        repeat (2) send_tick(press(0, 0, 1));
        send_tick(press(1, 0, 1));
        repeat (3) send_tick(press(1, 0, 1));
    endtask

    // Minimum above maximum: slower lands on the maximum, faster on the minimum.
    task automatic test_crossed_limits();
        set_chaser_regs(1, 255, 4000, 100);
        repeat (2) send_tick(press(0, 1, 0));
        send_tick(press(0, 0, 0));
        repeat (2) send_tick(press(0, 0, 1));
        send_tick(press(0, 0, 0));
    endtask

    // Random register settings with press, hold and release sequences on each button.
    task automatic test_random_presses();
        int  left [3];
        bit  held [3];
        int  deb;
        in_t btn;
        for (int b = 0; b < 3; b++) begin
            left[b] = 0;
            held[b] = 1'b1;
        end
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: set_chaser_regs($urandom_range(0, 4), $urandom_range(1, 8),
                                   $urandom_range(0, 5), $urandom_range(10, 40));
                1: set_chaser_regs(255, 255, 0, 4095);
                2: set_chaser_regs($urandom_range(0, 3), $urandom_range(1, 255),
                                   $urandom_range(20, 60), $urandom_range(0, 15));
                3: set_chaser_regs($urandom_range(0, 255), $urandom_range(0, 255),
                                   $urandom_range(0, 4095), $urandom_range(0, 4095));
                4: set_chaser_regs($urandom_range(1, 5), $urandom_range(1, 4),
                                   0, $urandom_range(5, 30));
                default: set_chaser_regs($urandom_range(0, 2), 1,
                                         $urandom_range(0, 3), $urandom_range(4, 12));
            endcase
            deb = int'(cfg_q.debounce_ticks);
            // One phase runs with neither side idling.
            steady = (phase == 4);
            repeat (PHASE_TICKS) begin
                for (int b = 0; b < 3; b++) begin
                    if (left[b] == 0) begin
                        held[b] = !held[b];
                        if (!held[b])
                            left[b] = $urandom_range(1, 4);
                        else if ($urandom_range(0, 3) == 0)
                            left[b] = $urandom_range(1, 3);
                        else
                            left[b] = $urandom_range(deb, deb + 4);
                    end
                    left[b]--;
                end
                btn = press(held[BTN_DIR], held[BTN_SLOWER], held[BTN_FASTER]);
                if ($urandom_range(0, 9) == 0)
                    btn = in_t'(3'($urandom_range(0, 7)));
                send_tick(btn);
            end
            steady = 1'b0;
        end
    endtask

    // The receiver stalls at random except during the steady stretch.
    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_leds_q.size() == 0) begin
                $error("result with no prediction waiting: %h", m_data);
                failures++;
            end else begin
                want_out = expected_leds_q.pop_front();
                results_checked++;
                if (m_data.led_pattern !== want_out.led_pattern) begin
                    $error("led_pattern: expected %b, actual %b",
                           want_out.led_pattern, m_data.led_pattern);
                    failures++;
                end
                if (m_data.direction !== want_out.direction) begin
                    $error("direction: expected %b, actual %b",
                           want_out.direction, m_data.direction);
                    failures++;
                end
                if (m_data.period !== want_out.period) begin
                    $error("period: expected %0d, actual %0d",
                           want_out.period, m_data.period);
                    failures++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        reset_chaser_model();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_after_reset();
        test_fast_presses();
        test_crossed_limits();
        test_random_presses();
        wait_results_drained();

        if (expected_leds_q.size() != 0) begin
            $error("%0d predicted results never arrived", expected_leds_q.size());
            failures++;
        end
        $display("Sent %0d ticks under %0d register settings; %0d results checked.",
                 ticks_sent, settings_written + 1, results_checked);
        $display("Covered zero debounce and period, crossed limits and held buttons.");
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### led_chaser_debounced_buttons.f
hw/rtl/lcdb_pkg.sv
hw/rtl/lcdb_debounce.sv
hw/rtl/lcdb_period.sv
hw/rtl/lcdb_chaser.sv
hw/rtl/led_chaser_debounced_buttons.sv
hw/rtl/lcdb_checker.sv
bench/led_chaser_debounced_buttons_tb.sv
